// ----- hw/rtl/sfrs_pkg.sv -----
package sfrs_pkg;

   localparam int ADDR_W = 24;
   localparam int LEN_W = 13;
   localparam int BLK_W = 12;
   localparam int OFF_W = 12;
   localparam int CSR_IDX_W = 2;
   localparam int PC_W = 5;
   localparam int CNT_W = 5;

   localparam int PAGE_BYTES_DEF = 256;

   localparam logic [LEN_W-1:0] BLOCK_BYTES_MAX = 13'd4096;
   localparam logic [LEN_W-1:0] BLOCK_BYTES_RST = 13'd4096;
   localparam logic [LEN_W-1:0] BLOCK_TOTAL_RST = 13'd4096;
   localparam logic [LEN_W-1:0] UNIT_RST = 13'd1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_BLOCK_BYTES = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BLOCK_TOTAL = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_READ_UNIT = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PROGRAM_UNIT = 2'd3;

   // request opcodes
   localparam logic [1:0] OP_READ = 2'd0;
   localparam logic [1:0] OP_PROGRAM = 2'd1;
   localparam logic [1:0] OP_ERASE = 2'd2;
   localparam logic [1:0] OP_SYNC = 2'd3;

   // frame kinds
   localparam logic [1:0] KIND_CMD = 2'd0;
   localparam logic [1:0] KIND_POLL = 2'd1;
   localparam logic [1:0] KIND_REJECT = 2'd2;
   localparam logic [1:0] KIND_EMPTY = 2'd3;

   // data directions
   localparam logic [1:0] DIR_NONE = 2'd0;
   localparam logic [1:0] DIR_TO_FLASH = 2'd1;
   localparam logic [1:0] DIR_FROM_FLASH = 2'd2;

   // flash commands
   localparam logic [7:0] CMD_READ = 8'h03;
   localparam logic [7:0] CMD_PAGE_PROGRAM = 8'h02;
   localparam logic [7:0] CMD_WRITE_ENABLE = 8'h06;
   localparam logic [7:0] CMD_SECTOR_ERASE = 8'h20;
   localparam logic [7:0] CMD_READ_STATUS = 8'h05;
   localparam logic [7:0] CMD_NONE = 8'h00;

   typedef enum logic [3:0] {
      ACT_NONE,
      ACT_LATCH,
      ACT_MUL,
      ACT_DIV_OFF,
      ACT_SAVE_OFF,
      ACT_DIV_LEN,
      ACT_SAVE_LEN,
      ACT_LOAD_ADDR,
      ACT_DIV_PAGE,
      ACT_SAVE_ROOM,
      ACT_STEP_CHUNK
   } act_type;

   typedef enum logic [2:0] {
      EMIT_NONE,
      EMIT_WE,
      EMIT_PP,
      EMIT_READ,
      EMIT_EMPTY,
      EMIT_REJECT,
      EMIT_POLL,
      EMIT_ERASE
   } emit_type;

   typedef enum logic [3:0] {
      COND_NEXT,
      COND_ALWAYS,
      COND_OP_SYNC,
      COND_OP_ERASE,
      COND_OP_READ,
      COND_CHECK_FAIL,
      COND_LEN_ZERO,
      COND_LAST_CHUNK,
      COND_BLK_BAD
   } cond_type;

   typedef struct packed {
      act_type act;
      emit_type emit;
      cond_type cond;
      logic [PC_W-1:0] target;
   } ucode_type;

   typedef struct packed {
      act_type act;
      emit_type emit;
      logic fire;
   } ctrl_type;

   typedef struct packed {
      logic req_valid;
      logic div_busy;
      logic out_full;
      logic op_sync;
      logic op_erase;
      logic op_read;
      logic len_zero;
      logic blk_bad;
      logic check_fail;
      logic last_chunk;
   } status_type;

   // program steps
   localparam logic [PC_W-1:0] STEP_WAIT = 5'd0;
   localparam logic [PC_W-1:0] STEP_MUL = 5'd1;
   localparam logic [PC_W-1:0] STEP_DISP_SYNC = 5'd2;
   localparam logic [PC_W-1:0] STEP_DISP_ERASE = 5'd3;
   localparam logic [PC_W-1:0] STEP_DIV_OFF = 5'd4;
   localparam logic [PC_W-1:0] STEP_SAVE_OFF = 5'd5;
   localparam logic [PC_W-1:0] STEP_DIV_LEN = 5'd6;
   localparam logic [PC_W-1:0] STEP_SAVE_LEN = 5'd7;
   localparam logic [PC_W-1:0] STEP_CHECK = 5'd8;
   localparam logic [PC_W-1:0] STEP_DISP_READ = 5'd9;
   localparam logic [PC_W-1:0] STEP_DISP_ZERO = 5'd10;
   localparam logic [PC_W-1:0] STEP_DIV_PAGE = 5'd11;
   localparam logic [PC_W-1:0] STEP_SAVE_ROOM = 5'd12;
   localparam logic [PC_W-1:0] STEP_LOOP = 5'd13;
   localparam logic [PC_W-1:0] STEP_PP = 5'd14;
   localparam logic [PC_W-1:0] STEP_BACK = 5'd15;
   localparam logic [PC_W-1:0] STEP_READ = 5'd16;
   localparam logic [PC_W-1:0] STEP_EMPTY = 5'd17;
   localparam logic [PC_W-1:0] STEP_REJECT = 5'd18;
   localparam logic [PC_W-1:0] STEP_SYNC = 5'd19;
   localparam logic [PC_W-1:0] STEP_ERASE_CHK = 5'd20;
   localparam logic [PC_W-1:0] STEP_ERASE_WE = 5'd21;
   localparam logic [PC_W-1:0] STEP_ERASE = 5'd22;

   function automatic ucode_type ucode_word(input logic [PC_W-1:0] pc);
      ucode_type w;
      w = '{act: ACT_NONE, emit: EMIT_NONE, cond: COND_NEXT, target: STEP_WAIT};
      case (pc)
         STEP_WAIT: w.act = ACT_LATCH;
         STEP_MUL: w.act = ACT_MUL;
         STEP_DISP_SYNC: begin
            w.cond = COND_OP_SYNC;
            w.target = STEP_SYNC;
         end
         STEP_DISP_ERASE: begin
            w.cond = COND_OP_ERASE;
            w.target = STEP_ERASE_CHK;
         end
         STEP_DIV_OFF: w.act = ACT_DIV_OFF;
         STEP_SAVE_OFF: w.act = ACT_SAVE_OFF;
         STEP_DIV_LEN: w.act = ACT_DIV_LEN;
         STEP_SAVE_LEN: w.act = ACT_SAVE_LEN;
         STEP_CHECK: begin
            w.act = ACT_LOAD_ADDR;
            w.cond = COND_CHECK_FAIL;
            w.target = STEP_REJECT;
         end
         STEP_DISP_READ: begin
            w.cond = COND_OP_READ;
            w.target = STEP_READ;
         end
         STEP_DISP_ZERO: begin
            w.cond = COND_LEN_ZERO;
            w.target = STEP_EMPTY;
         end
         STEP_DIV_PAGE: w.act = ACT_DIV_PAGE;
         STEP_SAVE_ROOM: w.act = ACT_SAVE_ROOM;
         STEP_LOOP: w.emit = EMIT_WE;
         STEP_PP: begin
            w.act = ACT_STEP_CHUNK;
            w.emit = EMIT_PP;
            w.cond = COND_LAST_CHUNK;
            w.target = STEP_WAIT;
         end
         STEP_BACK: begin
            w.cond = COND_ALWAYS;
            w.target = STEP_LOOP;
         end
         STEP_READ: begin
            w.emit = EMIT_READ;
            w.cond = COND_ALWAYS;
         end
         STEP_EMPTY: begin
            w.emit = EMIT_EMPTY;
            w.cond = COND_ALWAYS;
         end
         STEP_REJECT: begin
            w.emit = EMIT_REJECT;
            w.cond = COND_ALWAYS;
         end
         STEP_SYNC: begin
            w.emit = EMIT_POLL;
            w.cond = COND_ALWAYS;
         end
         STEP_ERASE_CHK: begin
            w.cond = COND_BLK_BAD;
            w.target = STEP_REJECT;
         end
         STEP_ERASE_WE: w.emit = EMIT_WE;
         STEP_ERASE: begin
            w.emit = EMIT_ERASE;
            w.cond = COND_ALWAYS;
         end
         default: w.cond = COND_ALWAYS;
      endcase
      return w;
   endfunction

endpackage

// ----- hw/rtl/sfrs_if.sv -----
interface sfrs_req_if;
   logic valid;
   logic ready;
   logic [1:0] opcode;
   logic [sfrs_pkg::BLK_W-1:0] block_index;
   logic [sfrs_pkg::OFF_W-1:0] byte_offset;
   logic [sfrs_pkg::LEN_W-1:0] byte_length;

   modport source (output valid, output opcode, output block_index, output byte_offset,
                   output byte_length, input ready);
   modport sink (input valid, input opcode, input block_index, input byte_offset,
                 input byte_length, output ready);
endinterface

interface sfrs_rsp_if;
   logic valid;
   logic ready;
   logic [1:0] frame_kind;
   logic poll_first;
   logic [7:0] command_byte;
   logic [sfrs_pkg::ADDR_W-1:0] flash_address;
   logic [sfrs_pkg::LEN_W-1:0] data_count;
   logic [1:0] data_direction;
   logic last;

   modport source (output valid, output frame_kind, output poll_first, output command_byte,
                   output flash_address, output data_count, output data_direction,
                   output last, input ready);
   modport sink (input valid, input frame_kind, input poll_first, input command_byte,
                 input flash_address, input data_count, input data_direction,
                 input last, output ready);
endinterface

// ----- hw/rtl/sfrs_rem_unit.sv -----
// Restoring remainder, one quotient bit per cycle.
module sfrs_rem_unit (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [sfrs_pkg::LEN_W-1:0] dividend,
   input  logic [sfrs_pkg::LEN_W-1:0] divisor,
   output logic busy,
   output logic [sfrs_pkg::LEN_W-1:0] remainder
);

   localparam int LW = sfrs_pkg::LEN_W;
   localparam int CW = sfrs_pkg::CNT_W;

   logic [CW-1:0] count_ff, count_in;
   logic [LW-1:0] shift_ff, shift_in;
   logic [LW:0] rem_ff, rem_in;
   logic [LW-1:0] div_ff, div_in;
   logic [LW:0] trial;

   assign trial = {rem_ff[LW-1:0], shift_ff[LW-1]};

   always_comb begin
      count_in = count_ff;
      shift_in = shift_ff;
      rem_in = rem_ff;
      div_in = div_ff;
      if (start) begin
         div_in = divisor;
         rem_in = '0;
         shift_in = dividend;
         count_in = CW'(LW);
      end else if (count_ff != '0) begin
         shift_in = {shift_ff[LW-2:0], 1'b0};
         count_in = count_ff - 1'b1;
         if (trial >= {1'b0, div_ff}) begin
            rem_in = trial - {1'b0, div_ff};
         end else begin
            rem_in = trial;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      shift_ff <= shift_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign busy = (count_ff != '0);
   assign remainder = rem_ff[LW-1:0];

endmodule

// ----- hw/rtl/sfrs_sequencer.sv -----
// Step counter over the control store, with conditional jumps.
module sfrs_sequencer (
   input  logic clock,
   input  logic reset,
   input  sfrs_pkg::status_type status,
   output sfrs_pkg::ctrl_type ctrl
);

   logic [sfrs_pkg::PC_W-1:0] pc_ff, pc_in;
   sfrs_pkg::ucode_type uword;
   logic stall;
   logic taken;

   assign uword = sfrs_pkg::ucode_word(pc_ff);

   always_comb begin
      stall = 1'b0;
      if (uword.act == sfrs_pkg::ACT_LATCH && !status.req_valid) begin
         stall = 1'b1;
      end
      if ((uword.act == sfrs_pkg::ACT_SAVE_OFF || uword.act == sfrs_pkg::ACT_SAVE_LEN ||
           uword.act == sfrs_pkg::ACT_SAVE_ROOM) && status.div_busy) begin
         stall = 1'b1;
      end
      if (uword.emit != sfrs_pkg::EMIT_NONE && status.out_full) begin
         stall = 1'b1;
      end
   end

   always_comb begin
      case (uword.cond)
         sfrs_pkg::COND_NEXT: taken = 1'b0;
         sfrs_pkg::COND_ALWAYS: taken = 1'b1;
         sfrs_pkg::COND_OP_SYNC: taken = status.op_sync;
         sfrs_pkg::COND_OP_ERASE: taken = status.op_erase;
         sfrs_pkg::COND_OP_READ: taken = status.op_read;
         sfrs_pkg::COND_CHECK_FAIL: taken = status.check_fail;
         sfrs_pkg::COND_LEN_ZERO: taken = status.len_zero;
         sfrs_pkg::COND_LAST_CHUNK: taken = status.last_chunk;
         sfrs_pkg::COND_BLK_BAD: taken = status.blk_bad;
         default: taken = 1'b1;
      endcase
   end

   always_comb begin
      pc_in = pc_ff;
      if (!stall) begin
         pc_in = taken ? uword.target : pc_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= sfrs_pkg::STEP_WAIT;
      end else begin
         pc_ff <= pc_in;
      end
   end

   assign ctrl.act = uword.act;
   assign ctrl.emit = uword.emit;
   assign ctrl.fire = !stall;

endmodule

// ----- hw/rtl/sfrs_datapath.sv -----
// Request registers, geometry checks, page split and the output register.
module sfrs_datapath #(
   parameter int PAGE_BYTES = sfrs_pkg::PAGE_BYTES_DEF
) (
   input  logic clock,
   input  logic reset,
   sfrs_req_if.sink req_bus,
   sfrs_rsp_if.source rsp_bus,
   input  logic csr_write_enable,
   input  logic [sfrs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [sfrs_pkg::LEN_W-1:0] csr_write_data,
   input  sfrs_pkg::ctrl_type ctrl,
   output sfrs_pkg::status_type status
);

   localparam int AW = sfrs_pkg::ADDR_W;
   localparam int LW = sfrs_pkg::LEN_W;
   localparam int BW = sfrs_pkg::BLK_W;
   localparam int OW = sfrs_pkg::OFF_W;
   localparam logic [LW-1:0] PAGE_W = LW'(PAGE_BYTES);
   localparam logic [AW-1:0] PAGE_A = AW'(PAGE_BYTES);

   // address mod page size: reciprocal multiply gives the quotient in one step,
   // the remainder follows from it in the next
   localparam int PG_L = $clog2(PAGE_BYTES);
   localparam int RECIP_SH = AW + PG_L;
   localparam int RECIP_W = AW + 2;
   localparam logic [RECIP_W-1:0] PG_RECIP =
      RECIP_W'(((64'd1 << RECIP_SH) / PAGE_BYTES) + 1);

   logic [LW-1:0] block_bytes_ff, block_total_ff, read_unit_ff, program_unit_ff;

   logic [1:0] op_ff;
   logic [BW-1:0] blk_ff;
   logic [OW-1:0] off_ff;
   logic [LW-1:0] len_ff;
   logic [AW-1:0] base_ff, base_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic [LW-1:0] left_ff, left_in;
   logic [LW-1:0] room_ff, room_in;
   logic [AW-1:0] quo_ff, quo_in;
   logic off_bad_ff, off_bad_in;
   logic len_bad_ff, len_bad_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic [1:0] kind_ff, kind_in;
   logic poll_ff, poll_in;
   logic [7:0] cmd_ff, cmd_in;
   logic [AW-1:0] faddr_ff, faddr_in;
   logic [LW-1:0] count_ff, count_in;
   logic [1:0] dir_ff, dir_in;
   logic last_ff, last_in;

   logic [LW-1:0] bsize;
   logic [LW-1:0] unit_sel, unit;
   logic [AW-1:0] product;
   logic [AW+RECIP_W-1:0] recip_prod;
   logic [AW-1:0] page_prod;
   logic [LW:0] span;
   logic [LW-1:0] chunk;
   logic last_chunk;
   logic accept;
   logic load_out;

   logic div_start, div_busy;
   logic [LW-1:0] div_dividend, div_rem;

   // config
   always_ff @(posedge clock) begin
      if (reset) begin
         block_bytes_ff <= sfrs_pkg::BLOCK_BYTES_RST;
         block_total_ff <= sfrs_pkg::BLOCK_TOTAL_RST;
         read_unit_ff <= sfrs_pkg::UNIT_RST;
         program_unit_ff <= sfrs_pkg::UNIT_RST;
      end else if (csr_write_enable) begin
         case (csr_index)
            sfrs_pkg::REG_BLOCK_BYTES: block_bytes_ff <= csr_write_data;
            sfrs_pkg::REG_BLOCK_TOTAL: block_total_ff <= csr_write_data;
            sfrs_pkg::REG_READ_UNIT: read_unit_ff <= csr_write_data;
            sfrs_pkg::REG_PROGRAM_UNIT: program_unit_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign bsize = (block_bytes_ff > sfrs_pkg::BLOCK_BYTES_MAX) ?
                  sfrs_pkg::BLOCK_BYTES_MAX : block_bytes_ff;
   assign unit_sel = (op_ff == sfrs_pkg::OP_PROGRAM) ? program_unit_ff : read_unit_ff;
   assign unit = (unit_sel == '0) ? LW'(1) : unit_sel;
   assign product = blk_ff * bsize;
   assign recip_prod = addr_ff * PG_RECIP;
   assign page_prod = quo_ff * PAGE_A;
   assign span = {2'b00, off_ff} + {1'b0, len_ff};
   assign chunk = (left_ff < room_ff) ? left_ff : room_ff;
   assign last_chunk = (left_ff <= room_ff);

   assign req_bus.ready = (ctrl.act == sfrs_pkg::ACT_LATCH) && !reset;
   assign accept = req_bus.valid && req_bus.ready;

   // remainder unit operand select
   always_comb begin
      div_start = 1'b0;
      div_dividend = {{(LW-OW){1'b0}}, off_ff};
      case (ctrl.act)
         sfrs_pkg::ACT_DIV_OFF: div_start = ctrl.fire;
         sfrs_pkg::ACT_DIV_LEN: begin
            div_start = ctrl.fire;
            div_dividend = len_ff;
         end
         default: ;
      endcase
   end

   sfrs_rem_unit u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (unit),
      .busy      (div_busy),
      .remainder (div_rem)
   );

   // working registers
   always_comb begin
      base_in = base_ff;
      addr_in = addr_ff;
      left_in = left_ff;
      room_in = room_ff;
      quo_in = quo_ff;
      off_bad_in = off_bad_ff;
      len_bad_in = len_bad_ff;
      if (ctrl.fire) begin
         case (ctrl.act)
            sfrs_pkg::ACT_MUL: base_in = product;
            sfrs_pkg::ACT_SAVE_OFF: off_bad_in = (div_rem != '0);
            sfrs_pkg::ACT_SAVE_LEN: len_bad_in = (div_rem != '0);
            sfrs_pkg::ACT_LOAD_ADDR: begin
               addr_in = base_ff + {{(AW-OW){1'b0}}, off_ff};
               left_in = len_ff;
            end
            sfrs_pkg::ACT_DIV_PAGE: quo_in = AW'(recip_prod >> RECIP_SH);
            sfrs_pkg::ACT_SAVE_ROOM: room_in = PAGE_W - LW'(addr_ff - page_prod);
            sfrs_pkg::ACT_STEP_CHUNK: begin
               addr_in = addr_ff + {{(AW-LW){1'b0}}, chunk};
               left_in = left_ff - chunk;
               room_in = PAGE_W;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff <= req_bus.opcode;
         blk_ff <= req_bus.block_index;
         off_ff <= req_bus.byte_offset;
         len_ff <= req_bus.byte_length;
      end
      base_ff <= base_in;
      addr_ff <= addr_in;
      left_ff <= left_in;
      room_ff <= room_in;
      quo_ff <= quo_in;
      off_bad_ff <= off_bad_in;
      len_bad_ff <= len_bad_in;
   end

   // status to the sequencer
   assign status.req_valid = req_bus.valid;
   assign status.div_busy = div_busy;
   assign status.out_full = rsp_valid_ff && !rsp_bus.ready;
   assign status.op_sync = (op_ff == sfrs_pkg::OP_SYNC);
   assign status.op_erase = (op_ff == sfrs_pkg::OP_ERASE);
   assign status.op_read = (op_ff == sfrs_pkg::OP_READ);
   assign status.len_zero = (left_ff == '0);
   assign status.blk_bad = ({1'b0, blk_ff} >= block_total_ff);
   assign status.check_fail = status.blk_bad || off_bad_ff || len_bad_ff ||
                              (span > {1'b0, bsize});
   assign status.last_chunk = last_chunk;

   // output register
   assign load_out = ctrl.fire && (ctrl.emit != sfrs_pkg::EMIT_NONE);

   always_comb begin
      kind_in = sfrs_pkg::KIND_CMD;
      poll_in = 1'b0;
      cmd_in = sfrs_pkg::CMD_NONE;
      faddr_in = '0;
      count_in = '0;
      dir_in = sfrs_pkg::DIR_NONE;
      last_in = 1'b1;
      case (ctrl.emit)
         sfrs_pkg::EMIT_WE: begin
            poll_in = 1'b1;
            cmd_in = sfrs_pkg::CMD_WRITE_ENABLE;
            last_in = 1'b0;
         end
         sfrs_pkg::EMIT_PP: begin
            cmd_in = sfrs_pkg::CMD_PAGE_PROGRAM;
            faddr_in = addr_ff;
            count_in = chunk;
            dir_in = sfrs_pkg::DIR_TO_FLASH;
            last_in = last_chunk;
         end
         sfrs_pkg::EMIT_READ: begin
            poll_in = 1'b1;
            cmd_in = sfrs_pkg::CMD_READ;
            faddr_in = addr_ff;
            count_in = len_ff;
            dir_in = sfrs_pkg::DIR_FROM_FLASH;
         end
         sfrs_pkg::EMIT_EMPTY: kind_in = sfrs_pkg::KIND_EMPTY;
         sfrs_pkg::EMIT_REJECT: kind_in = sfrs_pkg::KIND_REJECT;
         sfrs_pkg::EMIT_POLL: begin
            kind_in = sfrs_pkg::KIND_POLL;
            poll_in = 1'b1;
            cmd_in = sfrs_pkg::CMD_READ_STATUS;
         end
         sfrs_pkg::EMIT_ERASE: begin
            cmd_in = sfrs_pkg::CMD_SECTOR_ERASE;
            faddr_in = base_ff;
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (load_out) begin
         kind_ff <= kind_in;
         poll_ff <= poll_in;
         cmd_ff <= cmd_in;
         faddr_ff <= faddr_in;
         count_ff <= count_in;
         dir_ff <= dir_in;
         last_ff <= last_in;
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.frame_kind = kind_ff;
   assign rsp_bus.poll_first = poll_ff;
   assign rsp_bus.command_byte = cmd_ff;
   assign rsp_bus.flash_address = faddr_ff;
   assign rsp_bus.data_count = count_ff;
   assign rsp_bus.data_direction = dir_ff;
   assign rsp_bus.last = last_ff;

endmodule

// ----- hw/rtl/spi_flash_request_sequencer.sv -----
// SPI NOR flash request sequencer.
// req_bus takes one block-device request per beat (read, program, erase, sync);
// rsp_bus gives the flash command frames it causes, in order, with last set on
// the final frame of each request. csr_* writes the geometry registers and must
// only be used while no request is in flight.
// Order of events, receiver ready: a sync gives one poll frame; erase gives
// write enable then sector erase (a bad block is rejected instead). Read and
// program run two remainder checks (offset, length) on a shared bit-serial
// unit before a read frame or a rejection appears; an empty program then gives
// its empty frame. A program then works out the room left in the first page and
// issues write enable and page program for each page chunk in turn.
// The next request is taken the cycle after the final frame is registered.
// The remainder unit sets the pace of read and program.
// Reset (synchronous) returns the step counter to the wait step, empties the
// output register and loads the register defaults; req ready is low meanwhile.
// A stalled receiver holds the output register; the program waits on the step
// that wants to issue the next frame, so no beat is lost or repeated.
module spi_flash_request_sequencer #(
   parameter int PAGE_BYTES = sfrs_pkg::PAGE_BYTES_DEF
) (
   input  logic clock,
   input  logic reset,
   sfrs_req_if.sink req_bus,
   sfrs_rsp_if.source rsp_bus,
   input  logic csr_write_enable,
   input  logic [sfrs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [sfrs_pkg::LEN_W-1:0] csr_write_data
);

   // control word out, condition flags back
   sfrs_pkg::ctrl_type ctrl;
   sfrs_pkg::status_type status;

   sfrs_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   // geometry registers, checks, page split, output register
   sfrs_datapath #(
      .PAGE_BYTES (PAGE_BYTES)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .ctrl             (ctrl),
      .status           (status)
   );

endmodule

// ----- tb/testbench.sv -----
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int AW = sfrs_pkg::ADDR_W;
   localparam int LW = sfrs_pkg::LEN_W;
   localparam int BW = sfrs_pkg::BLK_W;
   localparam int OW = sfrs_pkg::OFF_W;

   // one block-device request as it crosses req_bus
   typedef struct {
      logic [1:0]    opcode;
      logic [BW-1:0] block_index;
      logic [OW-1:0] byte_offset;
      logic [LW-1:0] byte_length;
   } flash_req_type;

   // one flash command frame as it leaves on rsp_bus
   typedef struct {
      logic [1:0]    frame_kind;
      logic          poll_first;
      logic [7:0]    command_byte;
      logic [AW-1:0] flash_address;
      logic [LW-1:0] data_count;
      logic [1:0]    data_direction;
      logic          last;
   } flash_frame_type;

   localparam int PAGE = sfrs_pkg::PAGE_BYTES_DEF;

   logic                           clock;
   logic                           reset = 1'b1;
   logic                           csr_write_enable;
   logic [sfrs_pkg::CSR_IDX_W-1:0] csr_index;
   logic [LW-1:0]                  csr_write_data;

   sfrs_req_if req_bus ();
   sfrs_rsp_if rsp_bus ();

   spi_flash_request_sequencer u_top (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // our own copy of the geometry registers, kept in step with every csr write
   logic [LW-1:0] geo_block_bytes  = sfrs_pkg::BLOCK_BYTES_RST;
   logic [LW-1:0] geo_block_total  = sfrs_pkg::BLOCK_TOTAL_RST;
   logic [LW-1:0] geo_read_unit    = sfrs_pkg::UNIT_RST;
   logic [LW-1:0] geo_program_unit = sfrs_pkg::UNIT_RST;

   flash_req_type   req_backlog[$];   // requests still to be offered
   flash_frame_type frames_due[$];    // frames predicted but not yet seen
   int              mismatches = 0;

   int req_gap   = 0;
   bit req_quiet = 1'b0;
   int rsp_stall = 0;
   bit rsp_quiet = 1'b0;

   // clock, and every block input at a known level from time zero
   initial begin
      clock = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = sfrs_pkg::REG_BLOCK_BYTES;
      csr_write_data = '0;
      req_bus.valid = 1'b0;
      req_bus.opcode = sfrs_pkg::OP_READ;
      req_bus.block_index = '0;
      req_bus.byte_offset = '0;
      req_bus.byte_length = '0;
      rsp_bus.ready = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop, far beyond the slowest legal run
   initial begin
      #50_000_000;
      $display("FAIL");
      $finish;
   end

   // gap lengths: mostly short, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return $urandom_range(1, 2);
      if (r < 92) return $urandom_range(3, 8);
      return $urandom_range(20, 60);
   endfunction

   // granularity for the random geometry phases: powers of two or odd sizes
   function automatic int pick_unit();
      if ($urandom_range(0, 1) == 0) return 1 << $urandom_range(0, 6);
      return $urandom_range(1, 24);
   endfunction

   function automatic void add_frame(input logic [1:0] kind, input logic poll,
                                     input logic [7:0] cmd, input int unsigned addr,
                                     input int unsigned count, input logic [1:0] dir,
                                     input logic is_last);
      flash_frame_type f;
      f.frame_kind     = kind;
      f.poll_first     = poll;
      f.command_byte   = cmd;
      f.flash_address  = addr[AW-1:0];
      f.data_count     = count[LW-1:0];
      f.data_direction = dir;
      f.last           = is_last;
      frames_due.push_back(f);
   endfunction

   // Works out the frames one request gives under the current geometry.
   function automatic void plan_frames(input flash_req_type r);
      int unsigned bsize, base, unit, blk, off, len, addr, left, room, chunk;
      bit          fits;
      bsize = (geo_block_bytes > sfrs_pkg::BLOCK_BYTES_MAX) ?
              sfrs_pkg::BLOCK_BYTES_MAX : geo_block_bytes;
      blk   = r.block_index;
      off   = r.byte_offset;
      len   = r.byte_length;
      base  = blk * bsize;
      unit  = (r.opcode == sfrs_pkg::OP_PROGRAM) ? geo_program_unit : geo_read_unit;
      if (unit == 0) unit = 1;
      fits = (blk < geo_block_total) && (off % unit == 0) && (len % unit == 0)
             && (off + len <= bsize);
      case (r.opcode)
         sfrs_pkg::OP_SYNC: begin
            add_frame(sfrs_pkg::KIND_POLL, 1'b1, sfrs_pkg::CMD_READ_STATUS, 0, 0,
                      sfrs_pkg::DIR_NONE, 1'b1);
         end
         sfrs_pkg::OP_ERASE: begin
            // erase looks at the block number only
            if (blk >= geo_block_total) begin
               add_frame(sfrs_pkg::KIND_REJECT, 1'b0, sfrs_pkg::CMD_NONE, 0, 0,
                         sfrs_pkg::DIR_NONE, 1'b1);
            end else begin
               add_frame(sfrs_pkg::KIND_CMD, 1'b1, sfrs_pkg::CMD_WRITE_ENABLE, 0, 0,
                         sfrs_pkg::DIR_NONE, 1'b0);
               add_frame(sfrs_pkg::KIND_CMD, 1'b0, sfrs_pkg::CMD_SECTOR_ERASE, base, 0,
                         sfrs_pkg::DIR_NONE, 1'b1);
            end
         end
         sfrs_pkg::OP_READ: begin
            if (!fits) begin
               add_frame(sfrs_pkg::KIND_REJECT, 1'b0, sfrs_pkg::CMD_NONE, 0, 0,
                         sfrs_pkg::DIR_NONE, 1'b1);
            end else begin
               add_frame(sfrs_pkg::KIND_CMD, 1'b1, sfrs_pkg::CMD_READ, base + off, len,
                         sfrs_pkg::DIR_FROM_FLASH, 1'b1);
            end
         end
         default: begin
            if (!fits) begin
               add_frame(sfrs_pkg::KIND_REJECT, 1'b0, sfrs_pkg::CMD_NONE, 0, 0,
                         sfrs_pkg::DIR_NONE, 1'b1);
            end else if (len == 0) begin
               add_frame(sfrs_pkg::KIND_EMPTY, 1'b0, sfrs_pkg::CMD_NONE, 0, 0,
                         sfrs_pkg::DIR_NONE, 1'b1);
            end else begin
               // split at every page boundary of the full address
               addr = base + off;
               left = len;
               while (left != 0) begin
                  room  = PAGE - (addr % PAGE);
                  chunk = (left < room) ? left : room;
                  left  = left - chunk;
                  add_frame(sfrs_pkg::KIND_CMD, 1'b1, sfrs_pkg::CMD_WRITE_ENABLE, 0, 0,
                            sfrs_pkg::DIR_NONE, 1'b0);
                  add_frame(sfrs_pkg::KIND_CMD, 1'b0, sfrs_pkg::CMD_PAGE_PROGRAM, addr,
                            chunk, sfrs_pkg::DIR_TO_FLASH, left == 0);
                  addr = addr + chunk;
               end
            end
         end
      endcase
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatches++;
      end
   endtask

   // request driver: offers the backlog one beat at a time, with random gaps
   // between beats and the odd stretch of back-to-back offers
   always @(posedge clock) begin : req_drive
      flash_req_type nxt;
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_gap <= 0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (req_gap != 0) begin
            req_bus.valid <= 1'b0;
            req_gap <= req_gap - 1;
         end else if (req_backlog.size() != 0) begin
            nxt = req_backlog.pop_front();
            req_bus.valid       <= 1'b1;
            req_bus.opcode      <= nxt.opcode;
            req_bus.block_index <= nxt.block_index;
            req_bus.byte_offset <= nxt.byte_offset;
            req_bus.byte_length <= nxt.byte_length;
            if ($urandom_range(0, 31) == 0) req_quiet <= !req_quiet;
            req_gap <= (req_quiet || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // frame receiver: ready drops for random stalls, except in quiet stretches
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_stall <= 0;
      end else if (rsp_stall != 0) begin
         rsp_bus.ready <= 1'b0;
         rsp_stall <= rsp_stall - 1;
      end else begin
         rsp_bus.ready <= 1'b1;
         if ($urandom_range(0, 63) == 0) rsp_quiet <= !rsp_quiet;
         if (!rsp_quiet && $urandom_range(0, 2) == 0) rsp_stall <= pick_gap();
      end
   end

   // Monitor: each accepted frame against the oldest prediction, then each
   // accepted request into the prediction queue. Both handshakes are sampled
   // at the edge, so values are those from before the edge.
   always @(posedge clock) begin : frame_check
      flash_frame_type want;
      flash_req_type   took;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (frames_due.size() == 0) begin
               $error("frame beat with nothing predicted: kind 0x%0h cmd 0x%0h",
                      rsp_bus.frame_kind, rsp_bus.command_byte);
               mismatches++;
            end else begin
               want = frames_due.pop_front();
               check_field("frame_kind", want.frame_kind, rsp_bus.frame_kind);
               check_field("poll_first", want.poll_first, rsp_bus.poll_first);
               check_field("command_byte", want.command_byte, rsp_bus.command_byte);
               check_field("flash_address", want.flash_address, rsp_bus.flash_address);
               check_field("data_count", want.data_count, rsp_bus.data_count);
               check_field("data_direction", want.data_direction, rsp_bus.data_direction);
               check_field("last", want.last, rsp_bus.last);
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            took.opcode      = req_bus.opcode;
            took.block_index = req_bus.block_index;
            took.byte_offset = req_bus.byte_offset;
            took.byte_length = req_bus.byte_length;
            plan_frames(took);
         end
      end
   end

   task automatic write_reg(input logic [sfrs_pkg::CSR_IDX_W-1:0] idx,
                            input logic [LW-1:0] val);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= val;
      case (idx)
         sfrs_pkg::REG_BLOCK_BYTES:  geo_block_bytes = val;
         sfrs_pkg::REG_BLOCK_TOTAL:  geo_block_total = val;
         sfrs_pkg::REG_READ_UNIT:    geo_read_unit = val;
         sfrs_pkg::REG_PROGRAM_UNIT: geo_program_unit = val;
         default: ;
      endcase
   endtask

   // only called with the block idle
   task automatic write_geometry(input int bytes, input int total, input int rd_unit,
                                 input int pg_unit);
      write_reg(sfrs_pkg::REG_BLOCK_BYTES, LW'(bytes));
      write_reg(sfrs_pkg::REG_BLOCK_TOTAL, LW'(total));
      write_reg(sfrs_pkg::REG_READ_UNIT, LW'(rd_unit));
      write_reg(sfrs_pkg::REG_PROGRAM_UNIT, LW'(pg_unit));
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic queue_req(input logic [1:0] op, input int blk, input int off, input int len);
      flash_req_type r;
      r.opcode      = op;
      r.block_index = BW'(blk);
      r.byte_offset = OW'(off);
      r.byte_length = LW'(len);
      req_backlog.push_back(r);
   endtask

   // Mostly well-formed requests (block in range, aligned offset and length,
   // inside the block) so page splitting gets a real workout; a quarter are
   // raw noise across the full field ranges.
   task automatic queue_random(input int count);
      flash_req_type r;
      int unsigned unit, bsize, span, top, off_u, len_u, cap;
      repeat (count) begin
         r.opcode = 2'($urandom_range(0, 3));
         if ($urandom_range(0, 3) == 0) begin
            r.block_index = BW'($urandom);
            r.byte_offset = OW'($urandom);
            r.byte_length = LW'($urandom_range(0, 4096));
         end else begin
            unit = (r.opcode == sfrs_pkg::OP_PROGRAM) ? geo_program_unit : geo_read_unit;
            if (unit == 0) unit = 1;
            bsize = (geo_block_bytes > sfrs_pkg::BLOCK_BYTES_MAX) ?
                    sfrs_pkg::BLOCK_BYTES_MAX : geo_block_bytes;
            top = (geo_block_total > 4096) ? 4096 : geo_block_total;
            r.block_index = (top == 0) ? BW'($urandom) : BW'($urandom_range(0, top - 1));
            span  = bsize / unit;
            off_u = $urandom_range(0, span);
            if (off_u * unit > 4095) off_u = 0;
            // long transfers now and then, short ones mostly, to keep the run brisk
            cap = span - off_u;
            if ($urandom_range(0, 3) != 0 && cap > 520 / unit + 1) cap = 520 / unit + 1;
            len_u = $urandom_range(0, cap);
            r.byte_offset = OW'(off_u * unit);
            r.byte_length = LW'(len_u * unit);
         end
         req_backlog.push_back(r);
      end
   endtask

   // wait for the backlog and the prediction queue to drain, then let the
   // block finish stepping back to its wait step
   task automatic settle();
      do @(negedge clock);
      while (req_backlog.size() != 0 || req_bus.valid || frames_due.size() != 0);
      repeat (16) @(posedge clock);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // reset geometry, left as it came out of reset
      queue_req(sfrs_pkg::OP_SYNC, 4095, 4095, 4096);       // sync is never refused
      queue_req(sfrs_pkg::OP_ERASE, 0, 0, 0);
      queue_req(sfrs_pkg::OP_ERASE, 4095, 4095, 4096);      // offset and length ignored
      queue_req(sfrs_pkg::OP_READ, 0, 0, 0);                // empty read still one frame
      queue_req(sfrs_pkg::OP_READ, 4095, 0, 4096);
      queue_req(sfrs_pkg::OP_READ, 0, 4095, 1);
      queue_req(sfrs_pkg::OP_READ, 0, 4095, 2);             // runs past the block end
      queue_req(sfrs_pkg::OP_PROGRAM, 0, 0, 0);             // nothing to transfer
      queue_req(sfrs_pkg::OP_PROGRAM, 0, 0, 4096);          // whole block, 16 pages
      queue_req(sfrs_pkg::OP_PROGRAM, 7, 255, 2);           // straddles a page boundary
      queue_req(sfrs_pkg::OP_PROGRAM, 4095, 4095, 1);
      queue_req(sfrs_pkg::OP_PROGRAM, 0, 1, 4096);
      settle();

      // zero block size, zero units behave as one
      write_geometry(0, 1, 0, 0);
      queue_req(sfrs_pkg::OP_READ, 0, 0, 0);
      queue_req(sfrs_pkg::OP_PROGRAM, 0, 0, 0);
      queue_req(sfrs_pkg::OP_READ, 0, 0, 1);
      queue_req(sfrs_pkg::OP_ERASE, 1, 0, 0);
      queue_req(sfrs_pkg::OP_ERASE, 0, 100, 100);
      settle();

      // block size above range clamps to 4096
      write_geometry(8191, 4096, 3, 16);
      queue_req(sfrs_pkg::OP_READ, 4095, 3, 6);
      queue_req(sfrs_pkg::OP_READ, 0, 1, 3);                // misaligned offset
      queue_req(sfrs_pkg::OP_PROGRAM, 1, 16, 4064);
      queue_req(sfrs_pkg::OP_PROGRAM, 1, 8, 16);
      queue_req(sfrs_pkg::OP_PROGRAM, 2, 4080, 32);
      settle();

      // block base off the page grid
      write_geometry(1000, 5, 1, 8);
      queue_req(sfrs_pkg::OP_PROGRAM, 3, 40, 960);
      queue_req(sfrs_pkg::OP_ERASE, 5, 0, 0);
      queue_req(sfrs_pkg::OP_ERASE, 4, 0, 0);
      settle();

      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: write_geometry(4096, 4096, 1, 1);
            1: write_geometry(1, 1, 1, 1);
            2: write_geometry(4096, 4096, 4096, 4096);
            3: write_geometry(8191, 4095, 0, 256);
            default: write_geometry($urandom_range(1, 4096), $urandom_range(1, 4096),
                                    pick_unit(), pick_unit());
         endcase
         queue_random(51);
         settle();
      end

      repeat (40) @(posedge clock);
      if (mismatches == 0 && frames_due.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
